// ===== rtl/core/deque_with_remove_by_key_assert.svh =====
// Assertion shorthands for the deque checker.
`ifndef DEQUE_WITH_REMOVE_BY_KEY_ASSERT_SVH
`define DEQUE_WITH_REMOVE_BY_KEY_ASSERT_SVH

// Property checked at every rising clock edge outside reset.
`define DWRK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent now, consequent in the cycle after.
`define DWRK_ASSERT_NEXT(lbl, ante, cons, msg) \
  `DWRK_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== rtl/core/dwrk_pkg.sv =====
package dwrk_pkg;

  localparam int unsigned KEY_W     = 64;
  localparam int unsigned PAYLOAD_W = 64;
  localparam int unsigned OCC_W     = 8;

  typedef enum logic [1:0] {
    CMD_PUSH_BACK  = 2'd0,
    CMD_PUSH_FRONT = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_REMOVE     = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic                 ok;
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
    logic [OCC_W-1:0]     occupancy;
  } result_t;

endpackage

// ===== rtl/core/deque_with_remove_by_key.sv =====
// Bounded deque of key/payload entries with remove by key. Each request on
// the slave stream carries a command in tuser (push back, push front, pop
// front, remove by key) and an entry in tdata; each request yields exactly one
// result on the master stream: ok in tuser, and the returned key, payload and
// the count held afterwards in tdata. Entries live in a single ring buffer of
// CAPACITY slots (one write, one registered read port), so pushes and pops
// never move entries: they only change the head pointer and the count. A
// push back or push front goes from acceptance through an execute state and
// a result state back to idle; pop front adds a state for the registered
// read. Remove by key walks the buffer from the head, one read per cycle,
// then closes the gap by moving every later entry forward one slot, again
// one entry per cycle through the memory port. A failed request changes
// nothing and returns zero key and payload. Only one request is worked on at
// a time; a finished result waits in an output register, so the next request
// can be taken while it is still unclaimed. No clearing pass is needed after
// reset: slots beyond the count are never read.
module deque_with_remove_by_key #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // request stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // [63:0] entry_key, [127:64] entry_payload
  input  logic [1:0]   s_axis_tuser,  // [1:0] cmd
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata,  // [63:0] out_key, [127:64] out_payload,
                                      // [135:128] occupancy
  output logic         m_axis_tuser   // [0] ok
);
  import dwrk_pkg::*;

  // slot address and count widths
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  entry_t        req_entry;
  result_t       res;
  logic          res_valid, res_ready;
  logic          mem_rd_en, mem_wr_en;
  logic [AW-1:0] mem_rd_addr, mem_wr_addr;
  entry_t        mem_rd_data, mem_wr_data;

  // output register
  logic          out_valid_q;
  result_t       out_q;

  assign req_entry.key     = s_axis_tdata[63:0];
  assign req_entry.payload = s_axis_tdata[127:64];

  dwrk_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (s_axis_tvalid),
    .req_ready_o   (s_axis_tready),
    .req_cmd_i     (cmd_e'(s_axis_tuser)),
    .req_entry_i   (req_entry),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .mem_rd_en_o   (mem_rd_en),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_rd_data_i (mem_rd_data),
    .mem_wr_en_o   (mem_wr_en),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data)
  );

  dwrk_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data)
  );

  // result moves on when the register is empty or being drained
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.ok;
  assign m_axis_tdata  = {out_q.occupancy, out_q.payload, out_q.key};

endmodule

// ===== rtl/core/dwrk_mem.sv =====
// Entry store: one write port, one read port, registered read data.
module dwrk_mem #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output dwrk_pkg::entry_t rd_data_o,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  dwrk_pkg::entry_t wr_data_i
);
  import dwrk_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/dwrk_ctrl.sv =====
// Command sequencer: ring-buffer pointers, key search and gap closing.
module dwrk_ctrl #(
  parameter int unsigned CAPACITY = 128,
  parameter int unsigned AW       = 7,
  parameter int unsigned CW       = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  dwrk_pkg::cmd_e    req_cmd_i,
  input  dwrk_pkg::entry_t  req_entry_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output dwrk_pkg::result_t res_o,
  output logic              mem_rd_en_o,
  output logic [AW-1:0]     mem_rd_addr_o,
  input  dwrk_pkg::entry_t  mem_rd_data_i,
  output logic              mem_wr_en_o,
  output logic [AW-1:0]     mem_wr_addr_o,
  output dwrk_pkg::entry_t  mem_wr_data_o
);
  import dwrk_pkg::*;

  localparam int unsigned SW = CW + 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_POP    = 3'd2;
  localparam logic [2:0] ST_SEARCH = 3'd3;
  localparam logic [2:0] ST_SHIFT  = 3'd4;
  localparam logic [2:0] ST_RESULT = 3'd5;

  // logical position -> slot, head + idx stays below twice the capacity
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] idx);
    logic [SW-1:0] sum;
    sum = SW'(head) + SW'(idx);
    if (sum >= SW'(CAPACITY)) begin
      sum = sum - SW'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

  logic [2:0]     state_q, state_d;
  cmd_e           cmd_q, cmd_d;
  entry_t         entry_q, entry_d;
  logic [AW-1:0]  head_q, head_d;
  logic [CW-1:0]  count_q, count_d;
  logic [CW-1:0]  scan_q, scan_d;
  logic           rd_pend_q, rd_pend_d;
  logic [CW-1:0]  rd_idx_q, rd_idx_d;
  logic           wr_pend_q, wr_pend_d;
  logic [CW-1:0]  wr_idx_q, wr_idx_d;
  logic           res_ok_q, res_ok_d;
  entry_t         res_entry_q, res_entry_d;
  logic [AW-1:0]  new_head;
  logic           full, empty, scan_live;

  assign full      = (count_q == CW'(CAPACITY));
  assign empty     = (count_q == '0);
  assign scan_live = (scan_q < count_q);
  assign new_head  = (head_q == '0) ? AW'(CAPACITY - 1) : head_q - 1'b1;

  always_comb begin
    state_d       = state_q;
    cmd_d         = cmd_q;
    entry_d       = entry_q;
    head_d        = head_q;
    count_d       = count_q;
    scan_d        = scan_q;
    rd_pend_d     = 1'b0;
    rd_idx_d      = rd_idx_q;
    wr_pend_d     = 1'b0;
    wr_idx_d      = wr_idx_q;
    res_ok_d      = res_ok_q;
    res_entry_d   = res_entry_q;
    req_ready_o   = 1'b0;
    res_valid_o   = 1'b0;
    mem_rd_en_o   = 1'b0;
    mem_rd_addr_o = head_q;
    mem_wr_en_o   = 1'b0;
    mem_wr_addr_o = head_q;
    mem_wr_data_o = entry_q;

    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_d   = req_cmd_i;
          entry_d = req_entry_i;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_ok_d    = 1'b0;
        res_entry_d = '0;
        state_d     = ST_RESULT;
        case (cmd_q)
          CMD_PUSH_BACK: begin
            if (!full) begin
              mem_wr_en_o   = 1'b1;
              mem_wr_addr_o = phys(head_q, count_q);
              count_d       = count_q + 1'b1;
              res_ok_d      = 1'b1;
            end
          end
          CMD_PUSH_FRONT: begin
            if (!full) begin
              mem_wr_en_o   = 1'b1;
              mem_wr_addr_o = new_head;
              head_d        = new_head;
              count_d       = count_q + 1'b1;
              res_ok_d      = 1'b1;
            end
          end
          CMD_POP_FRONT: begin
            if (!empty) begin
              mem_rd_en_o   = 1'b1;
              mem_rd_addr_o = head_q;
              state_d       = ST_POP;
            end
          end
          default: begin
            if (!empty) begin
              scan_d  = '0;
              state_d = ST_SEARCH;
            end
          end
        endcase
      end
      ST_POP: begin
        res_ok_d    = 1'b1;
        res_entry_d = mem_rd_data_i;
        head_d      = (head_q == AW'(CAPACITY - 1)) ? '0 : head_q + 1'b1;
        count_d     = count_q - 1'b1;
        state_d     = ST_RESULT;
      end
      ST_SEARCH: begin
        // one read issued per cycle, compared as it returns
        if (scan_live) begin
          mem_rd_en_o   = 1'b1;
          mem_rd_addr_o = phys(head_q, scan_q);
          scan_d        = scan_q + 1'b1;
        end
        rd_pend_d = scan_live;
        rd_idx_d  = scan_q;
        if (rd_pend_q) begin
          if (mem_rd_data_i.key == entry_q.key) begin
            res_ok_d    = 1'b1;
            res_entry_d = mem_rd_data_i;
            scan_d      = rd_idx_q + 1'b1;
            rd_pend_d   = 1'b0;
            state_d     = ST_SHIFT;
          end else if (rd_idx_q == count_q - 1'b1) begin
            rd_pend_d = 1'b0;
            state_d   = ST_RESULT;
          end
        end
      end
      ST_SHIFT: begin
        // read position j+1, write it to j on the next cycle
        if (scan_live) begin
          mem_rd_en_o   = 1'b1;
          mem_rd_addr_o = phys(head_q, scan_q);
          scan_d        = scan_q + 1'b1;
        end
        wr_pend_d = scan_live;
        wr_idx_d  = scan_q - 1'b1;
        if (wr_pend_q) begin
          mem_wr_en_o   = 1'b1;
          mem_wr_addr_o = phys(head_q, wr_idx_q);
          mem_wr_data_o = mem_rd_data_i;
        end
        if (!scan_live && !wr_pend_q) begin
          count_d = count_q - 1'b1;
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_o.ok        = res_ok_q;
  assign res_o.key       = res_entry_q.key;
  assign res_o.payload   = res_entry_q.payload;
  assign res_o.occupancy = OCC_W'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      head_q    <= '0;
      count_q   <= '0;
      rd_pend_q <= 1'b0;
      wr_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      count_q   <= count_d;
      rd_pend_q <= rd_pend_d;
      wr_pend_q <= wr_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    entry_q     <= entry_d;
    scan_q      <= scan_d;
    rd_idx_q    <= rd_idx_d;
    wr_idx_q    <= wr_idx_d;
    res_ok_q    <= res_ok_d;
    res_entry_q <= res_entry_d;
  end

endmodule

// ===== rtl/core/dwrk_checker.sv =====
`include "deque_with_remove_by_key_assert.svh"

// Port-level checks on the deque.
module dwrk_checker #(
  parameter int unsigned CAPACITY = 128
) (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [135:0] m_axis_tdata,
  input logic         m_axis_tuser
);

  // stalled result holds
  `DWRK_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  // failed request returns no entry
  `DWRK_ASSERT(a_fail_zero, (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[127:0] == '0), "failed request returned data")

  // count never beyond capacity, checked only when CAPACITY fits in 8 bits
  `DWRK_ASSERT(a_occ_bound, m_axis_tvalid |-> ((CAPACITY > 255) || (m_axis_tdata[135:128] <= CAPACITY)), "occupancy above capacity")

  // one request in flight
  `DWRK_ASSERT_NEXT(a_one_req, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while busy")

endmodule

bind deque_with_remove_by_key dwrk_checker #(
  .CAPACITY (CAPACITY)
) u_dwrk_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
